FILE: rtl/plob_pkg.sv
// Shared types and constants for the price-level order book.
// No dependencies; imported by every other file in rtl/.
package plob_pkg;

  localparam int PRICE_W   = 32;
  localparam int QTY_W     = 32;
  localparam int DEPTH_W   = 5;
  localparam int MAX_DEPTH_DEF = 16;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

  typedef enum logic [2:0] {
    ACT_INSERTED = 3'd0,
    ACT_REPLACED = 3'd1,
    ACT_DELETED  = 3'd2,
    ACT_ABSENT   = 3'd3,
    ACT_REJECTED = 3'd4,
    ACT_CLEARED  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_REPLACE,
    OP_CLEAR
  } op_e;

  // one price level as held in a cell
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  // broadcast from side control to every cell
  typedef struct packed {
    op_e                op;
    logic               is_ask;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cell_ctl_t;

  // from top to one side
  typedef struct packed {
    logic               en;
    logic               clear;
    logic               is_ask;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } side_ctl_t;

endpackage

FILE: rtl/price_level_order_book.sv
// Top level of the price-level order book: item handshake, configuration
// register, result register, two plob_side chains. Depends on plob_pkg, plob_side.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------------
//  in       | in        | in_valid_i / in_stall_o | cmd_i side_i level_price_i level_quantity_i
//  out      | out       | out_valid_o / out_stall_i | action_o best_bid_* best_ask_* crossed
//  cfg      | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (level limit per side)
//
// Each transaction is accepted and registered, then in state EXEC every cell
// compares and shifts in parallel, then in state FIN the result register loads
// as the next item is accepted. A stalled result holds off the next item.
// Reset empties both sides and sets the level limit to 16; cfg is always ready.
module price_level_order_book import plob_pkg::*; #(
  parameter int MaxDepth = MAX_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic               side_i,
  input  logic [PRICE_W-1:0] level_price_i,
  input  logic [QTY_W-1:0]   level_quantity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         action_o,
  output logic [PRICE_W-1:0] best_bid_price_o,
  output logic               best_bid_valid_o,
  output logic [PRICE_W-1:0] best_ask_price_o,
  output logic               best_ask_valid_o,
  output logic               crossed_or_locked_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [DEPTH_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_FIN} state_e;

  state_e             state_q;
  logic [DEPTH_W-1:0] depth_q;
  logic               cmd_q, side_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  action_e            act_q;
  logic               out_valid_q;
  action_e            out_act_q;
  logic [PRICE_W-1:0] bid_px_q, ask_px_q;
  logic               bid_ok_q, ask_ok_q, cross_q;

  side_ctl_t bid_ctl, ask_ctl;
  action_e   bid_act, ask_act;
  entry_t    bid_head, ask_head;
  logic      out_free, in_acc, exec;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) || (state_q == ST_FIN && out_free));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign exec        = (state_q == ST_EXEC);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    bid_ctl = '{en: exec && !cmd_q && !side_q, clear: exec && cmd_q, is_ask: 1'b0,
                price: price_q, qty: qty_q};
    ask_ctl = '{en: exec && !cmd_q && side_q, clear: exec && cmd_q, is_ask: 1'b1,
                price: price_q, qty: qty_q};
  end

  plob_side #(.MaxDepth(MaxDepth)) u_bid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (bid_ctl),
    .depth_i  (depth_q),
    .action_o (bid_act),
    .head_o   (bid_head)
  );

  plob_side #(.MaxDepth(MaxDepth)) u_ask (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ask_ctl),
    .depth_i  (depth_q),
    .action_o (ask_act),
    .head_o   (ask_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= DEPTH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) depth_q <= cfg_data_i;
      // a finished item refills the result register as the old one leaves
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (in_acc) state_q <= ST_EXEC;
        ST_EXEC: state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) state_q <= in_acc ? ST_EXEC : ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // item and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_i;
      side_q  <= side_i;
      price_q <= level_price_i;
      qty_q   <= level_quantity_i;
    end
    if (exec) act_q <= cmd_q ? ACT_CLEARED : (side_q ? ask_act : bid_act);
    if (state_q == ST_FIN && out_free) begin
      out_act_q <= act_q;
      bid_ok_q  <= bid_head.valid;
      ask_ok_q  <= ask_head.valid;
      bid_px_q  <= bid_head.valid ? bid_head.price : '0;
      ask_px_q  <= ask_head.valid ? ask_head.price : '0;
      cross_q   <= bid_head.valid && ask_head.valid && (bid_head.price >= ask_head.price);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign action_o            = out_act_q;
  assign best_bid_price_o    = bid_px_q;
  assign best_bid_valid_o    = bid_ok_q;
  assign best_ask_price_o    = ask_px_q;
  assign best_ask_valid_o    = ask_ok_q;
  assign crossed_or_locked_o = cross_q;

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_act_q == ACT_CLEARED |-> !bid_ok_q && !ask_ok_q)
    else $error("clear result shows a level");

  a_cross_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cross_q |-> bid_ok_q && ask_ok_q)
    else $error("crossed flag without both sides");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EXEC)
    else $error("accepted transaction not executed");

endmodule

FILE: rtl/plob_cell.sv
// One price-level cell: holds a level, compares against the broadcast price
// and shifts with its neighbors. Depends on plob_pkg.
module plob_cell import plob_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      prev_ahead_i,
  input  entry_t    prev_i,
  input  entry_t    next_i,
  output logic      ahead_o,
  output logic      match_o,
  output entry_t    entry_o
);

  logic               valid_q, valid_d;
  logic [PRICE_W-1:0] price_q, price_d;
  logic [QTY_W-1:0]   qty_q, qty_d;

  always_comb begin
    ahead_o = valid_q && (ctl_i.is_ask ? (price_q < ctl_i.price) : (price_q > ctl_i.price));
    match_o = valid_q && (price_q == ctl_i.price);
  end

  always_comb begin
    valid_d = valid_q;
    price_d = price_q;
    qty_d   = qty_q;
    case (ctl_i.op)
      OP_CLEAR: valid_d = 1'b0;
      OP_REPLACE: begin
        if (match_o) qty_d = ctl_i.qty;
      end
      OP_INSERT: begin
        if (!ahead_o) begin
          if (prev_ahead_i) begin
            valid_d = 1'b1;
            price_d = ctl_i.price;
            qty_d   = ctl_i.qty;
          end else begin
            valid_d = prev_i.valid;
            price_d = prev_i.price;
            qty_d   = prev_i.qty;
          end
        end
      end
      OP_DELETE: begin
        if (!ahead_o) begin
          valid_d = next_i.valid;
          price_d = next_i.price;
          qty_d   = next_i.qty;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
  end

  assign entry_o = '{valid: valid_q, price: price_q, qty: qty_q};

endmodule

FILE: rtl/plob_side.sv
// One book side: a chain of plob_cell levels, best first, plus its level
// count and the insert/replace/delete decision. Depends on plob_pkg, plob_cell.
module plob_side import plob_pkg::*; #(
  parameter int MaxDepth = MAX_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  side_ctl_t          ctl_i,
  input  logic [DEPTH_W-1:0] depth_i,
  output action_e            action_o,
  output entry_t             head_o
);

  localparam int CntW = $clog2(MaxDepth + 1);
  localparam int CmpW = (CntW > DEPTH_W) ? CntW : DEPTH_W;

  logic [CntW-1:0] count_q, count_d;
  entry_t          ent   [MaxDepth];
  logic            ahead [MaxDepth];
  logic [MaxDepth-1:0] match;
  logic            found, full;
  cell_ctl_t       cell_ctl;
  entry_t          empty_ent;

  assign empty_ent = '{valid: 1'b0, price: '0, qty: '0};

  for (genvar i = 0; i < MaxDepth; i++) begin : g_cell
    logic   prev_ahead;
    entry_t prev_ent, next_ent;
    if (i == 0) begin : g_first
      assign prev_ahead = 1'b1;
      assign prev_ent   = empty_ent;
    end else begin : g_mid
      assign prev_ahead = ahead[i-1];
      assign prev_ent   = ent[i-1];
    end
    if (i == MaxDepth - 1) begin : g_last
      assign next_ent = empty_ent;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end
    plob_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl),
      .prev_ahead_i (prev_ahead),
      .prev_i       (prev_ent),
      .next_i       (next_ent),
      .ahead_o      (ahead[i]),
      .match_o      (match[i]),
      .entry_o      (ent[i])
    );
  end

  assign found = |match;
  assign full  = (count_q == CntW'(MaxDepth)) || (CmpW'(count_q) >= CmpW'(depth_i));

  always_comb begin
    action_o = ACT_ABSENT;
    if (ctl_i.qty == '0) begin
      action_o = found ? ACT_DELETED : ACT_ABSENT;
    end else if (found) begin
      action_o = ACT_REPLACED;
    end else begin
      action_o = full ? ACT_REJECTED : ACT_INSERTED;
    end
  end

  always_comb begin
    cell_ctl.is_ask = ctl_i.is_ask;
    cell_ctl.price  = ctl_i.price;
    cell_ctl.qty    = ctl_i.qty;
    cell_ctl.op     = OP_HOLD;
    count_d         = count_q;
    if (ctl_i.clear) begin
      cell_ctl.op = OP_CLEAR;
      count_d     = '0;
    end else if (ctl_i.en) begin
      case (action_o)
        ACT_INSERTED: begin
          cell_ctl.op = OP_INSERT;
          count_d     = count_q + 1'b1;
        end
        ACT_DELETED: begin
          cell_ctl.op = OP_DELETE;
          count_d     = count_q - 1'b1;
        end
        ACT_REPLACED: cell_ctl.op = OP_REPLACE;
        default:      cell_ctl.op = OP_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o = ent[0];

  a_count_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !ent[0].valid)
    else $error("level count disagrees with head cell");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxDepth))
    else $error("level count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.en && !ctl_i.clear && action_o == ACT_INSERTED |=>
      count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the side");

endmodule
